// ===== src/mcos_pkg.sv =====
`default_nettype none
package mcos_pkg;

    // request codes carried on s_tuser
    localparam logic [1:0] OP_SET_TARGET = 2'd0;
    localparam logic [1:0] OP_LOAD_SETUP = 2'd1;
    localparam logic [1:0] OP_TICK       = 2'd2;

    // lamp kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_SWITCH = 3'd1;
    localparam logic [2:0] KIND_PWM    = 3'd2;
    localparam logic [2:0] KIND_RGB    = 3'd3;
    localparam logic [2:0] KIND_DMX    = 3'd4;
    localparam logic [2:0] KIND_EXT_SW = 3'd5;
    localparam logic [2:0] KIND_EXT_DM = 3'd6;
    localparam logic [2:0] KIND_SIGNAL = 3'd7;

    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_FLUSH_HOLD   = 40;
    localparam int FLUSH_W          = 6;

    localparam logic [4:0]  CHANNEL_COUNT_RST = 5'd16;
    localparam logic [15:0] BLINK_PERIOD_RST  = 16'd50;

    localparam int REG_CHANNEL_COUNT = 0;
    localparam int REG_BLINK_PERIOD  = 1;

    // one channel entry as held in the state memory
    typedef struct packed {
        logic [7:0]  target;
        logic [7:0]  level;
        logic [15:0] countdown;
        logic [2:0]  kind;
        logic [3:0]  group;
        logic [15:0] length;
        logic        blinking;
        logic        normally_on;
    } mcos_entry_t;

    localparam int ENTRY_W = $bits(mcos_entry_t);

    // remainder unit status
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] rem;
    } mcos_mod_stat_t;

endpackage
`default_nettype wire

// ===== src/multi_channel_output_sequencer_core.sv =====
`default_nettype none
// channel   direction  handshake           payload
// s_        in         s_tvalid/s_tready   s_tuser op, s_tdata channel setup and target
// m_        out        m_tvalid/m_tready   m_tdata one channel result, m_tlast end of tick
// apb       in         psel/penable        channel_count, blink_period
//
// set target and load setup are an accept with memory read, then a write back
// a tick takes the accept, then a step and an emit with write back per walked channel,
// plus a wait on the bit-serial remainder unit for a blinking signal channel
// reset is synchronous, active low; all channel entries read as zero after it
// a full result register stalls the walk; a new request is taken once the walk is done
module multi_channel_output_sequencer_core #(
    parameter int MAX_CHANNELS = mcos_pkg::DEF_MAX_CHANNELS,
    parameter int FLUSH_HOLD   = mcos_pkg::DEF_FLUSH_HOLD
) (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tvalid/s_tready request channel
    input  wire         s_tvalid,
    output logic        s_tready,
    // [3:0] channel, [11:4] target, [14:12] kind, [18:15] relay_group,
    // [34:19] signal_length, [35] normally_on, [36] blinking
    input  wire  [39:0] s_tdata,
    // [1:0] op
    input  wire  [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  wire         m_tready,
    // [3:0] out_channel, [4] active, [12:5] level, [13] pin_high, [14] report,
    // [15] dmx_write, [16] dmx_flush, [32:17] relay_mask
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcos_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int N_W  = $clog2(MAX_CHANNELS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration registers
    logic [4:0]  channel_count_reg;
    logic [15:0] blink_period_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= CHANNEL_COUNT_RST;
            blink_period_reg  <= BLINK_PERIOD_RST;
        end else if (cfg_wr) begin
            if (32'(paddr[2]) == REG_CHANNEL_COUNT) begin
                channel_count_reg <= pwdata[4:0];
            end else begin
                blink_period_reg <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (32'(paddr[2]) == REG_CHANNEL_COUNT) begin
            prdata = {27'd0, channel_count_reg};
        end else begin
            prdata = {16'd0, blink_period_reg};
        end
    end

    // request fields
    logic [1:0]  in_op;
    logic [3:0]  in_channel;
    logic [7:0]  in_target;
    logic [2:0]  in_kind;
    logic [3:0]  in_group;
    logic [15:0] in_length;
    logic        in_nrm;
    logic        in_blink;

    assign in_op      = s_tuser;
    assign in_channel = s_tdata[3:0];
    assign in_target  = s_tdata[11:4];
    assign in_kind    = s_tdata[14:12];
    assign in_group   = s_tdata[18:15];
    assign in_length  = s_tdata[34:19];
    assign in_nrm     = s_tdata[35];
    assign in_blink   = s_tdata[36];

    // control and held request
    logic [1:0]         state_reg;
    logic [1:0]         op_reg;
    logic [CH_W-1:0]    idx_reg;
    logic [N_W-1:0]     n_reg;
    logic [15:0]        mask_reg;
    logic [FLUSH_W-1:0] flush_reg;
    logic [7:0]         target_reg;
    logic [2:0]         kind_reg;
    logic [3:0]         group_reg;
    logic [15:0]        length_reg;
    logic               nrm_reg;
    logic               blink_reg;

    // results of one channel step, held until the result register is free
    mcos_entry_t step_reg;
    logic        act_reg;
    logic        pin_reg;
    logic        rep_reg;
    logic        dw_reg;

    logic           accept;
    logic           ch_ok;
    logic [N_W-1:0] n_clamp;
    logic           last_ch;
    logic           fire;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ch_ok    = (32'(in_channel) < MAX_CHANNELS);
    assign last_ch  = (32'(idx_reg) + 1 == 32'(n_reg));
    assign fire     = (state_reg == S_EMIT) && (!m_tvalid || m_tready);

    always_comb begin
        if (channel_count_reg == 5'd0) begin
            n_clamp = N_W'(1);
        end else if (32'(channel_count_reg) > MAX_CHANNELS) begin
            n_clamp = N_W'(MAX_CHANNELS);
        end else begin
            n_clamp = N_W'(channel_count_reg);
        end
    end

    // state memory
    logic            rd_en;
    logic [CH_W-1:0] rd_addr;
    mcos_entry_t     rd_data;
    logic            wr_en;
    logic [CH_W-1:0] wr_addr;
    mcos_entry_t     wr_data;

    mcos_mem #(
        .DEPTH  (MAX_CHANNELS),
        .ADDR_W (CH_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // blink phase remainder
    logic           div_start;
    logic [15:0]    div_dividend;
    mcos_mod_stat_t div_stat;

    mcos_mod u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (blink_period_reg),
        .stat     (div_stat)
    );

    // channel step, combinational on the entry just read
    mcos_entry_t calc_e;
    mcos_entry_t merged;
    logic        calc_act;
    logic        calc_pin;
    logic        calc_rep;
    logic        calc_dw;
    logic        calc_div;
    logic [7:0]  calc_toward;
    logic [15:0] cd1;
    logic [15:0] cd2;

    always_comb begin
        calc_e       = rd_data;
        calc_act     = (rd_data.level != rd_data.target) || (rd_data.countdown != 16'd0);
        calc_pin     = (rd_data.kind == KIND_SIGNAL) ? rd_data.normally_on : 1'b0;
        calc_rep     = 1'b0;
        calc_dw      = 1'b0;
        calc_div     = 1'b0;
        cd1          = rd_data.countdown;
        cd2          = rd_data.countdown;
        div_dividend = rd_data.countdown;
        if (rd_data.target > rd_data.level) begin
            calc_toward = rd_data.level + 8'd1;
        end else if (rd_data.target < rd_data.level) begin
            calc_toward = rd_data.level - 8'd1;
        end else begin
            calc_toward = rd_data.level;
        end
        if (calc_act) begin
            unique case (rd_data.kind)
                KIND_SWITCH: begin
                    calc_e.level = {7'd0, rd_data.target != 8'd0};
                    calc_rep     = 1'b1;
                end
                KIND_PWM: begin
                    calc_e.level = calc_toward;
                end
                KIND_DMX: begin
                    calc_e.level = calc_toward;
                    calc_dw      = 1'b1;
                end
                KIND_EXT_SW, KIND_EXT_DM: begin
                    if (rd_data.level != rd_data.target) begin
                        calc_e.level = rd_data.target;
                        calc_rep     = 1'b1;
                    end
                end
                KIND_SIGNAL: begin
                    // a changed target triggers the countdown
                    if (rd_data.level != rd_data.target) begin
                        calc_e.level = rd_data.target;
                        cd1          = rd_data.length;
                        calc_rep     = 1'b1;
                    end
                    div_dividend = cd1;
                    if (cd1 != 16'd0) begin
                        calc_pin = !rd_data.normally_on;
                        cd2      = cd1 - 16'd1;
                        calc_div = rd_data.blinking;
                    end
                    calc_e.countdown = cd2;
                    if (cd2 == 16'd0) begin
                        calc_pin      = rd_data.normally_on;
                        calc_e.level  = 8'd0;
                        calc_e.target = 8'd0;
                        calc_rep      = 1'b1;
                        calc_div      = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end

        merged = rd_data;
        if (op_reg == OP_SET_TARGET) begin
            merged.target = target_reg;
        end else begin
            merged.kind        = kind_reg;
            merged.group       = group_reg;
            merged.length      = length_reg;
            merged.blinking    = blink_reg;
            merged.normally_on = nrm_reg;
        end
    end

    assign div_start = (state_reg == S_CALC) && (op_reg == OP_TICK) && calc_div;

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept && (in_op == OP_TICK)) begin
            rd_en = 1'b1;
        end else if (accept && ch_ok &&
                     (in_op == OP_SET_TARGET || in_op == OP_LOAD_SETUP)) begin
            rd_en   = 1'b1;
            rd_addr = CH_W'(in_channel);
        end else if (fire && !last_ch) begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + CH_W'(1);
        end
        wr_en   = fire || ((state_reg == S_CALC) && (op_reg != OP_TICK));
        wr_addr = idx_reg;
        wr_data = (state_reg == S_CALC) ? merged : step_reg;
    end

    // relay bit and flush of the channel being emitted
    logic [15:0]        relay_bit;
    logic [15:0]        mask_new;
    logic [FLUSH_W-1:0] flush_cur;

    always_comb begin
        relay_bit = 16'd0;
        if (step_reg.group != 4'd0 && step_reg.kind >= KIND_SWITCH &&
            step_reg.kind <= KIND_DMX && (step_reg.level | step_reg.target) != 8'd0) begin
            relay_bit = 16'd1 << step_reg.group;
        end
        mask_new  = mask_reg | relay_bit;
        flush_cur = dw_reg ? FLUSH_W'(FLUSH_HOLD) : flush_reg;
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_SET_TARGET;
            idx_reg   <= '0;
            n_reg     <= '0;
            mask_reg  <= '0;
            flush_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg   <= in_op;
                        idx_reg  <= CH_W'(in_channel);
                        mask_reg <= '0;
                        if (in_op == OP_TICK) begin
                            idx_reg   <= '0;
                            n_reg     <= n_clamp;
                            state_reg <= S_CALC;
                        end else if (ch_ok &&
                                     (in_op == OP_SET_TARGET || in_op == OP_LOAD_SETUP)) begin
                            state_reg <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (op_reg != OP_TICK) begin
                        state_reg <= S_IDLE;
                    end else if (calc_div) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (fire) begin
                        mask_reg  <= mask_new;
                        flush_reg <= flush_cur;
                        if (last_ch) begin
                            if (flush_cur != '0) begin
                                flush_reg <= flush_cur - FLUSH_W'(1);
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + CH_W'(1);
                            state_reg <= S_CALC;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // held request payload and step results
    always_ff @(posedge aclk) begin
        if (accept) begin
            target_reg <= in_target;
            kind_reg   <= in_kind;
            group_reg  <= in_group;
            length_reg <= in_length;
            nrm_reg    <= in_nrm;
            blink_reg  <= in_blink;
        end
        if (state_reg == S_CALC) begin
            step_reg <= calc_e;
            act_reg  <= calc_act;
            pin_reg  <= calc_pin;
            rep_reg  <= calc_rep;
            dw_reg   <= calc_dw;
        end else if ((state_reg == S_DIV) && div_stat.done) begin
            // on phase while the remainder is in the lower half of the period
            pin_reg <= (div_stat.rem < (blink_period_reg >> 1)) != step_reg.normally_on;
        end
    end

    // result register
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    logic        m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg[3:0]   <= 4'(idx_reg);
            m_tdata_reg[4]     <= act_reg;
            m_tdata_reg[12:5]  <= step_reg.level;
            m_tdata_reg[13]    <= pin_reg;
            m_tdata_reg[14]    <= rep_reg;
            m_tdata_reg[15]    <= dw_reg;
            m_tdata_reg[16]    <= last_ch && (flush_cur != '0);
            m_tdata_reg[32:17] <= last_ch ? mask_new : 16'd0;
            m_tdata_reg[39:33] <= 7'd0;
            m_tlast_reg        <= last_ch;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // relay mask and flush travel only on the final result of a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[32:16] == 17'd0))
        else $error("relay mask or flush on a non-final result");

    // waiting on the remainder only while the unit is running or finishing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("remainder wait with idle unit");

    // a result is loaded only when the register is free or being drained
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== src/mcos_mem.sv =====
`default_nettype none
module mcos_mem #(
    parameter int DEPTH  = mcos_pkg::DEF_MAX_CHANNELS,
    parameter int ADDR_W = 4
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          rd_en,
    input  wire  [ADDR_W-1:0]            rd_addr,
    output mcos_pkg::mcos_entry_t        rd_data,
    input  wire                          wr_en,
    input  wire  [ADDR_W-1:0]            wr_addr,
    input  mcos_pkg::mcos_entry_t        wr_data
);
    import mcos_pkg::*;

    mcos_entry_t      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    mcos_entry_t      rd_data_reg;
    logic             rd_valid_reg;

    // entry data, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // valid bits stand in for the all-zero reset of the entries
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule
`default_nettype wire

// ===== src/mcos_mod.sv =====
`default_nettype none
module mcos_mod (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  wire  [15:0]             dividend,
    input  wire  [15:0]             divisor,
    output mcos_pkg::mcos_mod_stat_t stat
);
    import mcos_pkg::*;

    logic [15:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] div_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [16:0] diff;

    // one restoring step per cycle
    always_comb begin
        trial = {rem_reg, quo_reg[15]};
        diff  = trial - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[14:0], 1'b0};
            rem_reg <= (trial >= {1'b0, div_reg}) ? diff[15:0] : trial[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg  <= 5'd16;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule
`default_nettype wire
